// ----- rtl/mi3_pkg.sv -----
// Shared constants, command and status types, and the cofactor operand schedule.
package mi3_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int OUT_WIDTH_DEF  = 32;
  localparam int CALC_W         = 64;
  localparam int FRAC_SHIFT     = 24;
  localparam int N_ELEM         = 9;
  localparam int ADDR_W         = 4;
  localparam int STEP_W         = 5;
  localparam int ENT_W          = 4;

  // Product schedule: steps 0..17 form the nine 2x2 minors, 18..20 the determinant.
  localparam logic [STEP_W-1:0] ADJ_STEPS  = 5'd18;
  localparam logic [STEP_W-1:0] LAST_ISSUE = 5'd20;
  localparam logic [STEP_W-1:0] CALC_END   = 5'd22;
  localparam logic [ADDR_W-1:0] LAST_ELEM  = 4'd8;
  localparam logic [ENT_W-1:0]  LAST_ENT   = 4'd8;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              clr;
    logic              iss_v;
    logic [STEP_W-1:0] iss_step;
    logic              div_start;
    logic [ENT_W-1:0]  ent;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic det_zero;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } opsel_t;

  // Element addresses for the two multiplier operands of each step. Even steps give
  // the first product of a minor, odd steps the product that is subtracted from it.
  function automatic opsel_t op_sel(input logic [STEP_W-1:0] step);
    opsel_t s;
    s = '{a: 4'd0, b: 4'd0};
    unique case (step)
      5'd0:  s = '{a: 4'd4, b: 4'd8};
      5'd1:  s = '{a: 4'd5, b: 4'd7};
      5'd2:  s = '{a: 4'd2, b: 4'd7};
      5'd3:  s = '{a: 4'd1, b: 4'd8};
      5'd4:  s = '{a: 4'd1, b: 4'd5};
      5'd5:  s = '{a: 4'd2, b: 4'd4};
      5'd6:  s = '{a: 4'd5, b: 4'd6};
      5'd7:  s = '{a: 4'd3, b: 4'd8};
      5'd8:  s = '{a: 4'd0, b: 4'd8};
      5'd9:  s = '{a: 4'd2, b: 4'd6};
      5'd10: s = '{a: 4'd2, b: 4'd3};
      5'd11: s = '{a: 4'd0, b: 4'd5};
      5'd12: s = '{a: 4'd3, b: 4'd7};
      5'd13: s = '{a: 4'd4, b: 4'd6};
      5'd14: s = '{a: 4'd1, b: 4'd6};
      5'd15: s = '{a: 4'd0, b: 4'd7};
      5'd16: s = '{a: 4'd0, b: 4'd4};
      5'd17: s = '{a: 4'd1, b: 4'd3};
      5'd18: s = '{a: 4'd0, b: 4'd0};
      5'd19: s = '{a: 4'd1, b: 4'd0};
      5'd20: s = '{a: 4'd2, b: 4'd0};
      default: s = '{a: 4'd0, b: 4'd0};
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/mi3_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module mi3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ----- rtl/mi3_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
module mi3_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mi3_pkg::CALC_W-1:0] num,
  input  logic [mi3_pkg::CALC_W-1:0] den,
  output logic [mi3_pkg::CALC_W-1:0] quot,
  output logic                       done
);

  localparam int W   = mi3_pkg::CALC_W;
  localparam int CW  = $clog2(W);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  always_comb begin
    rem_sh   = {rem_r, q_r[W-1]};
    diff     = rem_sh - {1'b0, den_r};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

// ----- rtl/mi3_dp.sv -----
// Datapath: element store, shared multiplier, adjugate and determinant registers, output.
module mi3_dp #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int OUT_WIDTH  = mi3_pkg::OUT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mi3_pkg::cmd_t         cmd,
  output mi3_pkg::status_t      sts,
  input  logic [ELEM_WIDTH-1:0] element,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_WIDTH-1:0]  out_entry,
  output logic                  out_singular,
  output logic                  out_saturated,
  output logic                  out_last
);

  localparam int W  = mi3_pkg::CALC_W;
  // A cofactor of ELEM_WIDTH-bit elements fits in 2*ELEM_WIDTH+1 signed bits.
  localparam int PW = (2 * ELEM_WIDTH + 1 < W) ? 2 * ELEM_WIDTH + 1 : W;
  localparam logic [W-1:0] MAXPOS = (64'd1 << (OUT_WIDTH - 1)) - 64'd1;
  localparam logic [W-1:0] MAXNEG = MAXPOS + 64'd1;

  logic [ELEM_WIDTH-1:0]     rd_a, rd_b;
  mi3_pkg::opsel_t           sel;
  logic                      s1_v_r;
  logic [mi3_pkg::STEP_W-1:0] s1_step_r;
  logic                      s2_v_r;
  logic [mi3_pkg::STEP_W-1:0] s2_step_r;
  logic signed [ELEM_WIDTH-1:0]    opa;
  logic signed [PW-1:0]            opb;
  logic signed [ELEM_WIDTH+PW-1:0] mul;
  logic [W-1:0]              adj_det;
  logic [W-1:0]              prod_r, acc_r, det_r;
  logic [W-1:0]              adj_r [mi3_pkg::N_ELEM];
  logic [W-1:0]              adj_cur, adj_mag, dmag, num, quot, qsig;
  logic                      dneg, neg, sat_hi, sat_lo, div_done;
  logic [W-1:0]              qsat;
  logic                      out_valid_r;
  logic [OUT_WIDTH-1:0]      out_entry_r;
  logic                      out_sing_r, out_sat_r, out_last_r;

  assign sel = mi3_pkg::op_sel(cmd.iss_step);

  mi3_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(mi3_pkg::N_ELEM)) u_store (
    .clk     (clk),
    .we      (cmd.wr_en),
    .waddr   (cmd.wr_addr),
    .wdata   (element),
    .raddr_a (sel.a),
    .raddr_b (sel.b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Determinant steps take the first-row cofactors (the first column of the adjugate) as the second operand.
  always_comb begin
    unique case (s1_step_r)
      5'd18:   adj_det = adj_r[0];
      5'd19:   adj_det = adj_r[3];
      default: adj_det = adj_r[6];
    endcase
    opa = rd_a;
    if (s1_step_r >= mi3_pkg::ADJ_STEPS) begin
      opb = adj_det[PW-1:0];
    end else begin
      opb = {{(PW - ELEM_WIDTH){rd_b[ELEM_WIDTH-1]}}, rd_b};
    end
  end

  // The multiplier is only as wide as an element times a cofactor.
  assign mul = opa * opb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.iss_v;
      s2_v_r <= s1_v_r;
    end
    s1_step_r <= cmd.iss_step;
    s2_step_r <= s1_step_r;
    prod_r    <= W'(mul);
    if (cmd.clr) begin
      det_r <= '0;
    end else if (s2_v_r) begin
      if (s2_step_r >= mi3_pkg::ADJ_STEPS) begin
        det_r <= det_r + prod_r;
      end else if (!s2_step_r[0]) begin
        acc_r <= prod_r;
      end else begin
        adj_r[s2_step_r[mi3_pkg::STEP_W-1:1]] <= acc_r - prod_r;
      end
    end
  end

  // Rounded magnitude division: (|adj| * 2^24 + |det| / 2) / |det|, wrapping in 64 bits.
  always_comb begin
    adj_cur = adj_r[cmd.ent];
    adj_mag = adj_cur[W-1] ? (W'(0) - adj_cur) : adj_cur;
    dneg    = det_r[W-1];
    dmag    = dneg ? (W'(0) - det_r) : det_r;
    num     = (adj_mag << mi3_pkg::FRAC_SHIFT) + (dmag >> 1);
    neg     = adj_cur[W-1] ^ dneg;
    sat_hi  = !neg && (quot > MAXPOS);
    sat_lo  = neg && (quot > MAXNEG);
    if (sat_hi) begin
      qsat = MAXPOS;
    end else if (sat_lo) begin
      qsat = MAXNEG;
    end else begin
      qsat = quot;
    end
    qsig = neg ? (W'(0) - qsat) : qsat;
  end

  mi3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (dmag),
    .quot  (quot),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_last_r <= (cmd.ent == mi3_pkg::LAST_ENT);
      if (det_r == '0) begin
        out_entry_r <= '0;
        out_sing_r  <= 1'b1;
        out_sat_r   <= 1'b0;
      end else begin
        out_entry_r <= qsig[OUT_WIDTH-1:0];
        out_sing_r  <= 1'b0;
        out_sat_r   <= sat_hi | sat_lo;
      end
    end
  end

  assign sts.div_done   = div_done;
  assign sts.det_zero   = (det_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_entry      = out_entry_r;
  assign out_singular   = out_sing_r;
  assign out_saturated  = out_sat_r;
  assign out_last       = out_last_r;

endmodule

// ----- rtl/mi3_ctrl.sv -----
// Controller: element loading, product schedule, division and output sequencing.
module mi3_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mi3_pkg::status_t sts,
  output mi3_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [mi3_pkg::ADDR_W-1:0]  count_r, count_nxt;
  logic [mi3_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [mi3_pkg::ENT_W-1:0]   ent_r, ent_nxt;
  logic                        acc;

  assign in_ready = (state_r == S_LOAD);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    ent_nxt       = ent_r;
    cmd           = '0;
    cmd.wr_addr   = count_r;
    cmd.iss_step  = step_r;
    cmd.ent       = ent_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.wr_en = acc;
        if (acc) begin
          if (count_r == mi3_pkg::LAST_ELEM) begin
            count_nxt = '0;
            step_nxt  = '0;
            state_nxt = S_CALC;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      S_CALC: begin
        cmd.clr   = (step_r == '0);
        cmd.iss_v = (step_r <= mi3_pkg::LAST_ISSUE);
        step_nxt  = step_r + 1'b1;
        if (step_r == mi3_pkg::CALC_END) begin
          ent_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.det_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          ent_nxt      = ent_r + 1'b1;
          state_nxt    = (ent_r == mi3_pkg::LAST_ENT) ? S_LOAD : S_DIV;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      step_r  <= '0;
      ent_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      ent_r   <= ent_nxt;
    end
  end

endmodule

// ----- rtl/matrix_inverse_3x3.sv -----
// Top level: 3x3 matrix inverse by the adjugate method, Q8.8 elements in, Q16.16 out.
// Nine element transfers are taken at one per cycle while loading; then the minors and
// determinant are formed on one shared multiplier, and each entry takes one division (one
// quotient bit per cycle) plus sequencing; a singular matrix skips the divisions.
// Synchronous active-low reset returns to element loading with the element count at zero.
module matrix_inverse_3x3 #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
  parameter int OUT_WIDTH  = mi3_pkg::OUT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: element.
  input  logic [((ELEM_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: inverse_entry.
  output logic [((OUT_WIDTH+7)/8)*8-1:0]  out_tdata,
  // Fields from bit 0: singular, saturated.
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  mi3_pkg::cmd_t        cmd;
  mi3_pkg::status_t     sts;
  logic [OUT_WIDTH-1:0] entry;
  logic                 singular, saturated;

  // The controller sequences loading, the product schedule and the divisions; the
  // datapath holds the store, the multiplier, the divider and the output register.
  mi3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mi3_dp #(.ELEM_WIDTH(ELEM_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .element       (in_tdata[ELEM_WIDTH-1:0]),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_entry     (entry),
    .out_singular  (singular),
    .out_saturated (saturated),
    .out_last      (out_tlast)
  );

  // The entry is zero-filled up to a whole number of bytes.
  assign out_tdata = OUT_TDATA_W'(entry);
  assign out_tuser = {saturated, singular};

endmodule

// ----- tb/mi3_checker.sv -----
// Checker for the 3x3 matrix inverse: watches both channels, predicts entries, compares.
module mi3_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [31:0] entry;
    logic        singular;
    logic        saturated;
    logic        last;
  } inv_entry_t;

  inv_entry_t      inverse_q[$];
  logic [63:0]     held[9];
  int              held_count;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Builds the adjugate and determinant of the held matrix and queues nine entries.
  task automatic predict_inverse();
    logic [63:0] adj[9];
    logic [63:0] det, dmag, num, q;
    logic        neg, sat;
    inv_entry_t  r;
    adj[0] = held[4] * held[8] - held[5] * held[7];
    adj[1] = held[2] * held[7] - held[1] * held[8];
    adj[2] = held[1] * held[5] - held[2] * held[4];
    adj[3] = held[5] * held[6] - held[3] * held[8];
    adj[4] = held[0] * held[8] - held[2] * held[6];
    adj[5] = held[2] * held[3] - held[0] * held[5];
    adj[6] = held[3] * held[7] - held[4] * held[6];
    adj[7] = held[1] * held[6] - held[0] * held[7];
    adj[8] = held[0] * held[4] - held[1] * held[3];
    det  = held[0] * adj[0] + held[1] * adj[3] + held[2] * adj[6];
    dmag = mag64(det);
    for (int k = 0; k < 9; k++) begin
      r.last = (k == 8);
      if (dmag == 0) begin
        r.entry = '0; r.singular = 1'b1; r.saturated = 1'b0;
      end else begin
        neg = adj[k][63] != det[63];
        num = mag64(adj[k]) << 24;
        q   = (num + (dmag >> 1)) / dmag;
        sat = 1'b0;
        if (!neg && q > 64'h7fff_ffff) begin
          q = 64'h7fff_ffff; sat = 1'b1;
        end
        if (neg && q > 64'h8000_0000) begin
          q = 64'h8000_0000; sat = 1'b1;
        end
        q = neg ? (64'd0 - q) : q;
        r.entry = q[31:0]; r.singular = 1'b0; r.saturated = sat;
      end
      inverse_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    inv_entry_t exp_e;
    if (!rst_n) begin
      held_count <= 0;
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        held[held_count] = {{48{in_tdata[15]}}, in_tdata};
        if (held_count == 8) begin
          predict_inverse();
          held_count <= 0;
        end else begin
          held_count <= held_count + 1;
        end
      end
      if (out_tvalid && out_tready) begin
        if (inverse_q.size() == 0) begin
          $error("unexpected result transfer: entry %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = inverse_q.pop_front();
          if (out_tdata !== exp_e.entry || out_tuser[0] !== exp_e.singular ||
              out_tuser[1] !== exp_e.saturated || out_tlast !== exp_e.last) begin
            fail_count <= fail_count + 1;
            if (out_tdata !== exp_e.entry)
              $error("inverse_entry: expected %h, got %h", exp_e.entry, out_tdata);
            if (out_tuser[0] !== exp_e.singular)
              $error("singular: expected %b, got %b", exp_e.singular, out_tuser[0]);
            if (out_tuser[1] !== exp_e.saturated)
              $error("saturated: expected %b, got %b", exp_e.saturated, out_tuser[1]);
            if (out_tlast !== exp_e.last)
              $error("last: expected %b, got %b", exp_e.last, out_tlast);
          end
        end
      end
    end
    pending = inverse_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives matrices into the inverse block and gives the verdict.
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;

  // Idle percentages for the sender and the receiver; changed between phases.
  int          send_idle_pct = 26;
  int          recv_stall_pct = 60;
  int          cycle_count = 0;

  always #5 clk = ~clk;

  matrix_inverse_3x3 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  mi3_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // A hard cycle limit guards against a hung block. The slowest correct run is
  // 25 matrices, stretched by stalls on the result side, so the limit leaves a
  // wide margin.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one element and holds it until the transfer happens. The ready
  // signal is sampled at the falling edge, where it is stable, so the
  // transfer is known to happen at the following rising edge.
  task automatic send_element(input logic [15:0] elem);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= elem;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_matrix(input logic [15:0] m[9]);
    for (int k = 0; k < 9; k++) send_element(m[k]);
  endtask

  task automatic send_random_matrix();
    logic [15:0] m[9];
    int          kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 5) m[k] = 16'($urandom());
      else if (kind < 7) m[k] = 16'($urandom_range(1023) - 512);
      else m[k] = 16'($urandom_range(15) - 8);
    end
    // Every so often one row repeats another, so the matrix is singular.
    if (kind == 9 || kind == 4)
      for (int c = 0; c < 3; c++) m[6 + c] = m[c];
    send_matrix(m);
  endtask

  initial begin
    logic [15:0] m[9];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A determinant of one with huge off-diagonal cofactors clips both ways.
    m = '{16'd1, 16'h7fff, 16'd0, 16'd0, 16'd1, 16'h8000, 16'd0, 16'd0, 16'd1};
    send_matrix(m);
    // All elements at the most negative value give a singular matrix.
    m = '{default: 16'h8000};
    send_matrix(m);
    // A diagonal matrix with extreme and unit entries.
    m = '{16'h7fff, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'h0100};
    send_matrix(m);

    // Random matrices in three idling phases: sender light and receiver heavy,
    // then the reverse, then no idling at all.
    for (int n = 0; n < 22; n++) begin
      if (n == 8) begin
        send_idle_pct = 60; recv_stall_pct = 26;
      end else if (n == 16) begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      send_random_matrix();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (700) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mi3_pkg.sv
rtl/mi3_ram.sv
rtl/mi3_div.sv
rtl/mi3_dp.sv
rtl/mi3_ctrl.sv
rtl/matrix_inverse_3x3.sv
tb/mi3_checker.sv
tb/tb.sv
